// ----- rtl/core/nsc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// nsc_pkg
// Shared types and constants of the NMEA sentence capture block.
// ----------------------------------------------------------------------------
package nsc_pkg;

    localparam int SENTENCE_BYTES = 128;
    localparam int ADDR_W         = $clog2(SENTENCE_BYTES);
    localparam int BYTE_W         = 8;
    localparam int POS_W          = 8;
    localparam int LEN_W          = 8;

    localparam logic [POS_W-1:0] SENT_LEN = POS_W'(SENTENCE_BYTES);
    localparam logic [POS_W-1:0] MIN_FINISH_IDX = 8'd6;

    localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
    localparam logic [BYTE_W-1:0] CH_STAR   = 8'h2A;
    localparam logic [BYTE_W-1:0] CH_G      = 8'h47;
    localparam logic [BYTE_W-1:0] CH_A      = 8'h41;
    localparam logic [BYTE_W-1:0] CH_R      = 8'h52;
    localparam logic [BYTE_W-1:0] CH_M      = 8'h4D;
    localparam logic [BYTE_W-1:0] CH_C      = 8'h43;

    // positions of the talker-free sentence type
    localparam logic [ADDR_W-1:0] HDR_POS0 = ADDR_W'(3);
    localparam logic [ADDR_W-1:0] HDR_POS1 = ADDR_W'(4);
    localparam logic [ADDR_W-1:0] HDR_POS2 = ADDR_W'(5);

    typedef enum logic [1:0] {
        MODE_RX    = 2'd0,
        MODE_READ  = 2'd1,
        MODE_REARM = 2'd2
    } t_mode;

    typedef struct packed {
        logic [BYTE_W-1:0] c3;
        logic [BYTE_W-1:0] c4;
        logic [BYTE_W-1:0] c5;
    } t_hdr;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [BYTE_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_store_req;

endpackage : nsc_pkg
`default_nettype wire

// ----- rtl/core/nsc_store.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// nsc_store
// One sentence store: single-port-write, registered-read byte memory with a
// shadow copy of the sentence type bytes at positions 3 to 5.
// ----------------------------------------------------------------------------
module nsc_store (
    input  wire logic                        i_clk,
    input  wire nsc_pkg::t_store_req         i_req,
    output logic [nsc_pkg::BYTE_W-1:0]       o_rd_data,
    output nsc_pkg::t_hdr                    o_hdr
);
    import nsc_pkg::*;

    logic [BYTE_W-1:0] r_mem [SENTENCE_BYTES];
    logic [BYTE_W-1:0] r_rd_data;
    t_hdr              r_hdr;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rd_data <= r_mem[i_req.raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            if (i_req.waddr == HDR_POS0) begin
                r_hdr.c3 <= i_req.wdata;
            end
            if (i_req.waddr == HDR_POS1) begin
                r_hdr.c4 <= i_req.wdata;
            end
            if (i_req.waddr == HDR_POS2) begin
                r_hdr.c5 <= i_req.wdata;
            end
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_hdr     = r_hdr;

endmodule : nsc_store
`default_nettype wire

// ----- rtl/core/nmea_sentence_capture.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// nmea_sentence_capture
// Captures GGA and RMC sentences from received UART bytes into two stores.
// ----------------------------------------------------------------------------
// At acceptance both stores are read at the address the item needs (two
// places behind the capture index, or the requested read position). The
// item waits in the stage register until the output register can take the
// result; then the sentence end test, store write back and index and length
// updates are done and the result goes into the output register. A new
// item is accepted only once the previous one has left the stage register;
// the result register lets the next item enter while a result still
// waits. Lengths of 0 mean the store is still capturing; a finished store
// holds its sentence until a re-arm item or an overlong sentence clears it.
// ----------------------------------------------------------------------------
module nmea_sentence_capture (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic                          i_cfg_rx_enable,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [1:0]                    i_mode,
    input  wire logic [nsc_pkg::BYTE_W-1:0]    i_rx_byte,
    input  wire logic                          i_store_select,
    input  wire logic [6:0]                    i_read_position,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [nsc_pkg::BYTE_W-1:0]         o_read_data,
    output logic [nsc_pkg::LEN_W-1:0]          o_gga_length,
    output logic [nsc_pkg::LEN_W-1:0]          o_rmc_length
);
    import nsc_pkg::*;

    logic              r_rx_enable;
    logic [POS_W-1:0]  r_position, n_position;
    logic [LEN_W-1:0]  r_gga_len, n_gga_len;
    logic [LEN_W-1:0]  r_rmc_len, n_rmc_len;

    logic              r_s2_valid;
    t_mode             r_s2_mode;
    logic [BYTE_W-1:0] r_s2_byte;
    logic              r_s2_sel;
    logic [6:0]        r_s2_rpos;

    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_data, n_out_data;

    logic              in_fire, s2_fire;
    t_store_req        gga_req, rmc_req;
    logic [BYTE_W-1:0] gga_rd, rmc_rd;
    t_hdr              gga_hdr, rmc_hdr;

    logic [POS_W-1:0]  idx_g, idx_r;
    logic              gga_fin, rmc_fin;
    logic [ADDR_W-1:0] rd_addr;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = ~r_s2_valid;
    assign in_fire     = i_in_valid & o_in_ready;
    assign s2_fire     = r_s2_valid & (~r_out_valid | i_out_ready);

    // read address for the end test or the read item
    always_comb begin
        if (t_mode'(i_mode) == MODE_READ) begin
            rd_addr = ADDR_W'(i_read_position);
        end else begin
            rd_addr = ADDR_W'(r_position - POS_W'(2));
        end
    end

    nsc_store u_gga_store (
        .i_clk     (i_clk),
        .i_req     (gga_req),
        .o_rd_data (gga_rd),
        .o_hdr     (gga_hdr)
    );

    nsc_store u_rmc_store (
        .i_clk     (i_clk),
        .i_req     (rmc_req),
        .o_rd_data (rmc_rd),
        .o_hdr     (rmc_hdr)
    );

    // end test, write back and state update
    always_comb begin
        n_position = r_position;
        n_gga_len  = r_gga_len;
        n_rmc_len  = r_rmc_len;
        n_out_data = '0;
        idx_g      = r_position;
        idx_r      = r_position;
        gga_fin    = 1'b0;
        rmc_fin    = 1'b0;

        gga_req.we    = 1'b0;
        gga_req.waddr = '0;
        gga_req.wdata = '0;
        gga_req.re    = in_fire;
        gga_req.raddr = rd_addr;
        rmc_req.we    = 1'b0;
        rmc_req.waddr = '0;
        rmc_req.wdata = '0;
        rmc_req.re    = in_fire;
        rmc_req.raddr = rd_addr;

        case (r_s2_mode)
            MODE_RX: begin
                if (r_rx_enable) begin
                    if (r_s2_byte == CH_DOLLAR) begin
                        idx_g = '0;
                    end
                    if (idx_g >= SENT_LEN) begin
                        idx_g     = '0;
                        n_gga_len = '0;
                        n_rmc_len = '0;
                    end
                    idx_r = idx_g;
                    if (n_gga_len == '0) begin
                        gga_req.we    = s2_fire;
                        gga_req.waddr = idx_g[ADDR_W-1:0];
                        gga_req.wdata = r_s2_byte;
                        gga_fin = (idx_g > MIN_FINISH_IDX) && (gga_rd == CH_STAR) &&
                                  (gga_hdr.c3 == CH_G) && (gga_hdr.c4 == CH_G) &&
                                  (gga_hdr.c5 == CH_A);
                        if (gga_fin) begin
                            n_gga_len = LEN_W'(idx_g + POS_W'(1));
                            idx_r     = '0;
                        end
                    end
                    if (n_rmc_len == '0) begin
                        rmc_req.we    = s2_fire;
                        rmc_req.waddr = idx_r[ADDR_W-1:0];
                        rmc_req.wdata = r_s2_byte;
                        rmc_fin = (idx_r > MIN_FINISH_IDX) && (rmc_rd == CH_STAR) &&
                                  (rmc_hdr.c3 == CH_R) && (rmc_hdr.c4 == CH_M) &&
                                  (rmc_hdr.c5 == CH_C);
                        if (rmc_fin) begin
                            n_rmc_len = LEN_W'(idx_r + POS_W'(1));
                            idx_r     = '0;
                        end
                    end
                    n_position = idx_r + POS_W'(1);
                end
            end
            MODE_READ: begin
                if (POS_W'(r_s2_rpos) < SENT_LEN) begin
                    n_out_data = r_s2_sel ? rmc_rd : gga_rd;
                end
            end
            MODE_REARM: begin
                n_gga_len     = '0;
                n_rmc_len     = '0;
                gga_req.we    = s2_fire;
                rmc_req.we    = s2_fire;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_enable <= 1'b1;
            r_position  <= '0;
            r_gga_len   <= '0;
            r_rmc_len   <= '0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_rx_enable <= i_cfg_rx_enable;
            end
            if (in_fire) begin
                r_s2_valid <= 1'b1;
            end else if (s2_fire) begin
                r_s2_valid <= 1'b0;
            end
            if (s2_fire) begin
                r_out_valid <= 1'b1;
                r_position  <= n_position;
                r_gga_len   <= n_gga_len;
                r_rmc_len   <= n_rmc_len;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s2_mode <= t_mode'(i_mode);
            r_s2_byte <= i_rx_byte;
            r_s2_sel  <= i_store_select;
            r_s2_rpos <= i_read_position;
        end
        if (s2_fire) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_read_data  = r_out_data;
    assign o_gga_length = r_gga_len;
    assign o_rmc_length = r_rmc_len;

endmodule : nmea_sentence_capture
`default_nettype wire

// ----- rtl/core/nsc_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// nsc_checker
// Port-level checks of the NMEA sentence capture block.
// ----------------------------------------------------------------------------
module nsc_checker (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          o_out_valid,
    input  wire logic                          i_out_ready,
    input  wire logic [nsc_pkg::BYTE_W-1:0]    o_read_data,
    input  wire logic [nsc_pkg::LEN_W-1:0]     o_gga_length,
    input  wire logic [nsc_pkg::LEN_W-1:0]     o_rmc_length
);
    import nsc_pkg::*;

    localparam logic [LEN_W-1:0] MIN_LEN = LEN_W'(MIN_FINISH_IDX + POS_W'(2));
    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(SENTENCE_BYTES);

    logic             r_prev_valid;
    logic [LEN_W-1:0] r_prev_gga;
    logic [LEN_W-1:0] r_prev_rmc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_valid <= 1'b0;
        end else if (o_out_valid && i_out_ready) begin
            r_prev_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_out_valid && i_out_ready) begin
            r_prev_gga <= o_gga_length;
            r_prev_rmc <= o_rmc_length;
        end
    end

    a_gga_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_gga_length == '0) ||
                        ((o_gga_length >= MIN_LEN) && (o_gga_length <= MAX_LEN)))
        else $error("gga length out of range");

    a_rmc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_rmc_length == '0) ||
                        ((o_rmc_length >= MIN_LEN) && (o_rmc_length <= MAX_LEN)))
        else $error("rmc length out of range");

    a_len_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && r_prev_valid) |->
            ((r_prev_gga == '0) || (o_gga_length == r_prev_gga) || (o_gga_length == '0)) &&
            ((r_prev_rmc == '0) || (o_rmc_length == r_prev_rmc) || (o_rmc_length == '0)))
        else $error("finished length changed without clearing");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_read_data) && $stable(o_gga_length) &&
             $stable(o_rmc_length)))
        else $error("stalled item changed");

endmodule : nsc_checker

bind nmea_sentence_capture nsc_checker u_nsc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_read_data  (o_read_data),
    .o_gga_length (o_gga_length),
    .o_rmc_length (o_rmc_length)
);
`default_nettype wire

// ----- tb/sv/nmea_sentence_capture_tb.sv -----
// ----------------------------------------------------------------------------
// nmea_sentence_capture_tb
// Self-checking bench for the GGA/RMC sentence capture block. A bit-accurate
// predictor tracks the shared index, both stores and the finished lengths,
// and every result is compared against it. Both stores are filled once
// after reset, then directed sentences, receiver disable, a steady stream
// and randomized sentence traffic with random stalls on both sides.
// ----------------------------------------------------------------------------
module nmea_sentence_capture_tb;
    import nsc_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int IDLE_PERCENT   = 29;
    localparam int STEADY_ITEMS   = 100;
    localparam int RANDOM_ITEMS   = 380;
    localparam int DRAIN_CYCLES   = 8;
    localparam logic [1:0] MODE_SPARE = 2'd3;

    typedef struct packed {
        logic [BYTE_W-1:0] read_data;
        logic [LEN_W-1:0]  gga_length;
        logic [LEN_W-1:0]  rmc_length;
    } t_capture_status;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic              cfg_rx_enable = 1'b1;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic [1:0]        in_mode = MODE_RX;
    logic [BYTE_W-1:0] in_rx_byte = '0;
    logic              in_store_select = 1'b0;
    logic [6:0]        in_read_position = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [BYTE_W-1:0] read_data;
    logic [LEN_W-1:0]  gga_length;
    logic [LEN_W-1:0]  rmc_length;

    // predicted block state
    logic              rx_on = 1'b1;
    logic [POS_W-1:0]  next_pos = '0;
    logic [BYTE_W-1:0] gga_img [SENTENCE_BYTES];
    logic [BYTE_W-1:0] rmc_img [SENTENCE_BYTES];
    logic [LEN_W-1:0]  gga_done = '0;
    logic [LEN_W-1:0]  rmc_done = '0;

    t_capture_status status_q [$];
    int  mismatch_count = 0;
    int  active_items = 0;
    int  quiet_cycles = 0;
    bit  idle_on = 1'b1;

    nmea_sentence_capture dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_rx_enable (cfg_rx_enable),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_mode          (in_mode),
        .i_rx_byte       (in_rx_byte),
        .i_store_select  (in_store_select),
        .i_read_position (in_read_position),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_read_data     (read_data),
        .o_gga_length    (gga_length),
        .o_rmc_length    (rmc_length)
    );

    always #10 clk = ~clk;

    // writes one store and tests for a finished sentence
    function automatic bit store_byte(input bit to_rmc, input logic [POS_W-1:0] idx,
                                      input logic [BYTE_W-1:0] b);
        if (idx >= SENT_LEN) return 1'b0;
        if (to_rmc) rmc_img[idx[ADDR_W-1:0]] = b;
        else gga_img[idx[ADDR_W-1:0]] = b;
        if (idx <= MIN_FINISH_IDX) return 1'b0;
        if (to_rmc) begin
            return rmc_img[ADDR_W'(idx - POS_W'(2))] == CH_STAR && rmc_img[3] == CH_R &&
                   rmc_img[4] == CH_M && rmc_img[5] == CH_C;
        end
        return gga_img[ADDR_W'(idx - POS_W'(2))] == CH_STAR && gga_img[3] == CH_G &&
               gga_img[4] == CH_G && gga_img[5] == CH_A;
    endfunction

    function automatic void take_byte(input logic [BYTE_W-1:0] b);
        logic [POS_W-1:0] idx;
        idx = next_pos;
        if (b == CH_DOLLAR) idx = '0;
        if (idx >= SENT_LEN) begin
            idx = '0;
            gga_done = '0;
            rmc_done = '0;
        end
        if (gga_done == 0) begin
            if (store_byte(1'b0, idx, b)) begin
                gga_done = idx + 1'b1;
                idx = '0;
            end
        end
        if (rmc_done == 0) begin
            if (store_byte(1'b1, idx, b)) begin
                rmc_done = idx + 1'b1;
                idx = '0;
            end
        end
        next_pos = idx + 1'b1;
    endfunction

    function automatic t_capture_status capture_item(input logic [1:0] mode,
            input logic [BYTE_W-1:0] b, input logic sel, input logic [6:0] rd_pos);
        t_capture_status st;
        st.read_data = '0;
        case (mode)
            MODE_RX: begin
                if (rx_on) take_byte(b);
            end
            MODE_READ: begin
                st.read_data = sel ? rmc_img[rd_pos] : gga_img[rd_pos];
            end
            MODE_REARM: begin
                gga_done = '0;
                rmc_done = '0;
                gga_img[0] = '0;
                rmc_img[0] = '0;
            end
            default: ;
        endcase
        st.gga_length = gga_done;
        st.rmc_length = rmc_done;
        return st;
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    task automatic send_item(input logic [1:0] mode, input logic [BYTE_W-1:0] b,
                             input logic sel, input logic [6:0] rd_pos);
        @(negedge clk);
        while (idle_on && $urandom_range(0, 99) < IDLE_PERCENT) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid         <= 1'b1;
        in_mode          <= mode;
        in_rx_byte       <= b;
        in_store_select  <= sel;
        in_read_position <= rd_pos;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        status_q.push_back(capture_item(mode, b, sel, rd_pos));
        if (!(mode == MODE_RX && !rx_on)) active_items++;
    endtask

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        send_item(MODE_RX, b, 1'($urandom), 7'($urandom));
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (status_q.size() != 0) @(posedge clk);
    endtask

    task automatic write_rx_enable(input logic value);
        wait_drained();
        @(negedge clk);
        cfg_valid     <= 1'b1;
        cfg_rx_enable <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        rx_on = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [BYTE_W-1:0] plain_byte();
        logic [BYTE_W-1:0] c;
        do c = 8'($urandom); while (c == CH_DOLLAR || c == CH_STAR);
        return c;
    endfunction

    function automatic logic [BYTE_W-1:0] field_char();
        logic [BYTE_W-1:0] c;
        if ($urandom_range(0, 19) == 0) return 8'($urandom);
        do c = 8'($urandom_range(32, 126)); while (c == CH_DOLLAR || c == CH_STAR);
        return c;
    endfunction

    function automatic logic [BYTE_W-1:0] hex_char();
        string digits;
        digits = "0123456789ABCDEF";
        return digits[$urandom_range(0, 15)];
    endfunction

    // talker, sentence type, fields, checksum; some cut short or corrupted
    task automatic send_sentence();
        logic [BYTE_W-1:0] text [$];
        int body_len;
        int flaw;
        int n;
        text.push_back(CH_DOLLAR);
        text.push_back(CH_G);
        text.push_back(8'($urandom_range(65, 90)));
        case ($urandom_range(0, 4))
            0, 1: begin
                text.push_back(CH_G);
                text.push_back(CH_G);
                text.push_back(CH_A);
            end
            2, 3: begin
                text.push_back(CH_R);
                text.push_back(CH_M);
                text.push_back(CH_C);
            end
            default: begin
                repeat (3) text.push_back(8'($urandom_range(65, 90)));
            end
        endcase
        body_len = ($urandom_range(0, 19) == 0) ? $urandom_range(110, 135)
                                                : $urandom_range(0, 40);
        repeat (body_len) text.push_back(field_char());
        text.push_back(CH_STAR);
        text.push_back(hex_char());
        text.push_back(hex_char());
        n = text.size();
        flaw = $urandom_range(0, 19);
        if (flaw == 0) n = $urandom_range(1, text.size() - 1);
        else if (flaw == 1) text[$urandom_range(1, text.size() - 1)] = 8'($urandom);
        for (int i = 0; i < n; i++) send_byte(text[i]);
    endtask

    task automatic send_random_unit();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55) send_sentence();
        else if (pick < 68) send_item(MODE_REARM, 8'($urandom), 1'($urandom), 7'($urandom));
        else if (pick < 83) send_item(MODE_READ, 8'($urandom), 1'($urandom), 7'($urandom));
        else if (pick < 88) send_item(MODE_SPARE, 8'($urandom), 1'($urandom), 7'($urandom));
        else repeat ($urandom_range(1, 5)) send_byte(8'($urandom));
    endtask

    // one full pass writes every entry of both stores, then the index wraps
    task automatic test_store_fill();
        send_byte(8'h00);
        send_byte(8'hFF);
        for (int i = 2; i < SENTENCE_BYTES; i++) send_byte(plain_byte());
        send_byte(plain_byte());
    endtask

    task automatic test_sentence_end();
        send_text("$GPGGA*4F");
        send_item(MODE_READ, 8'hFF, 1'b0, 7'd8);
        // rmc took the last gga byte at position 0
        send_item(MODE_READ, 8'h00, 1'b1, 7'd0);
        send_item(MODE_READ, 8'h00, 1'b0, 7'h7F);
        send_item(MODE_READ, 8'hFF, 1'b1, 7'h7F);
        send_item(MODE_SPARE, 8'hFF, 1'b1, 7'h7F);
        send_text("$GNRMC*1A");
        send_item(MODE_REARM, 8'h00, 1'b0, 7'd0);
        send_item(MODE_READ, 8'h00, 1'b0, 7'd0);
        send_byte(8'h00);
        send_byte(8'hFF);
    endtask

    task automatic test_rx_disable();
        write_rx_enable(1'b0);
        send_text("$GPGGA*00");
        send_item(MODE_READ, 8'h00, 1'b0, 7'd3);
        send_item(MODE_REARM, 8'h00, 1'b1, 7'd0);
        write_rx_enable(1'b1);
        write_rx_enable(1'b1);
        send_text("$GPGGA,1*00");
    endtask

    task automatic test_steady_stream();
        int target;
        target = active_items + STEADY_ITEMS;
        idle_on = 1'b0;
        while (active_items < target) send_random_unit();
        wait_drained();
        idle_on = 1'b1;
    endtask

    task automatic test_random_traffic();
        int target;
        target = active_items + RANDOM_ITEMS;
        while (active_items < target) begin
            if ($urandom_range(0, 19) == 0) write_rx_enable($urandom_range(0, 3) != 0);
            send_random_unit();
        end
    endtask

    always @(negedge clk) begin
        out_ready <= !idle_on || $urandom_range(0, 99) >= IDLE_PERCENT;
    end

    always @(posedge clk) begin : status_check
        t_capture_status want;
        if (rst_n && out_valid && out_ready) begin
            if (status_q.size() == 0) begin
                report_mismatch("result with no item pending");
            end else begin
                want = status_q.pop_front();
                if (read_data !== want.read_data)
                    report_mismatch($sformatf("read_data %h, want %h",
                                              read_data, want.read_data));
                if (gga_length !== want.gga_length)
                    report_mismatch($sformatf("gga_length %0d, want %0d",
                                              gga_length, want.gga_length));
                if (rmc_length !== want.rmc_length)
                    report_mismatch($sformatf("rmc_length %0d, want %0d",
                                              rmc_length, want.rmc_length));
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL nmea_sentence_capture");
            $finish;
        end
    end

    initial begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_store_fill();
        test_sentence_end();
        test_rx_disable();
        test_steady_stream();
        test_random_traffic();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0) begin
            $display("PASS nmea_sentence_capture");
        end else begin
            $display("FAIL nmea_sentence_capture");
        end
        $finish;
    end

endmodule
